// ----- rtl/wsed_pkg.sv -----
// ----------------------------------------------------------------------------
// wsed_pkg
// Types, widths and constants shared by the warm-up shelf EQ decimator.
// ----------------------------------------------------------------------------
package wsed_pkg;

    localparam int SAMP_W    = 16;
    localparam int FRM_W     = 10;
    localparam int CNT_W     = 8;
    localparam int COEF_W    = 26;
    localparam int XH_W      = 16;
    localparam int YH_W      = 24;
    localparam int MB_W      = 24;
    localparam int MP_W      = COEF_W + MB_W;
    localparam int ACC_W     = 54;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int QUO_W     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = COEF_W;

    localparam int COEF_FRAC_DEF = 20;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC;

    localparam logic [CFG_IDX_W-1:0] CFG_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE = 3'd6;

    localparam logic signed [COEF_W-1:0] RST_B0 = 26'sd5719886;
    localparam logic signed [COEF_W-1:0] RST_B1 = -26'sd8973925;
    localparam logic signed [COEF_W-1:0] RST_B2 = 26'sd3698401;
    localparam logic signed [COEF_W-1:0] RST_A1 = -26'sd935541;
    localparam logic signed [COEF_W-1:0] RST_A2 = 26'sd331326;
    localparam logic [CNT_W-1:0]         RST_MUTE = 8'd20;
    localparam logic [CNT_W-1:0]         RST_FADE = 8'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_DIV,
        S_GGO,
        S_GMUL,
        S_TAPGO,
        S_TAP,
        S_ABS,
        S_RND,
        S_SGN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [COEF_W-1:0] a;
        logic signed [MB_W-1:0]   b;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [MP_W-1:0]  p;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

// ----- rtl/wsed_in_if.sv -----
// ----------------------------------------------------------------------------
// wsed_in_if
// Input stream: one 16 kHz sample with its frame count per transaction.
// ----------------------------------------------------------------------------
interface wsed_in_if;
    import wsed_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SAMP_W-1:0] sample_in;
    logic [FRM_W-1:0]         frames_done;

    modport source (output valid, output sample_in, output frames_done, input ready);
    modport sink   (input valid, input sample_in, input frames_done, output ready);
endinterface

// ----- rtl/wsed_out_if.sv -----
// ----------------------------------------------------------------------------
// wsed_out_if
// Output stream: one 8 kHz PCM sample per transaction.
// ----------------------------------------------------------------------------
interface wsed_out_if;
    import wsed_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SAMP_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

// ----- rtl/wsed_div.sv -----
// ----------------------------------------------------------------------------
// wsed_div
// Restoring divider, one quotient bit per cycle: (num << 15) / den, num < den.
// ----------------------------------------------------------------------------
module wsed_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsed_pkg::t_div_req  i_req,
    output wsed_pkg::t_div_rsp  o_rsp
);
    import wsed_pkg::*;

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_den, n_den;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [CNT_W:0]    w_dbl;
    logic [CNT_W:0]    w_sub;
    logic              w_ge;

    always_comb begin
        w_dbl  = {r_rem, 1'b0};
        w_sub  = w_dbl - {1'b0, r_den};
        w_ge   = w_dbl >= {1'b0, r_den};
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_cnt  = STEP_W'(QUO_W);
            n_busy = 1'b1;
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = w_ge ? w_sub[CNT_W-1:0] : w_dbl[CNT_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], w_ge};
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- rtl/wsed_smul.sv -----
// ----------------------------------------------------------------------------
// wsed_smul
// Bit-serial signed multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module wsed_smul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsed_pkg::t_mul_req  i_req,
    output wsed_pkg::t_mul_rsp  o_rsp
);
    import wsed_pkg::*;

    localparam int STEP_W = $clog2(MB_W + 1);

    logic [STEP_W-1:0]        r_cnt, n_cnt;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic signed [COEF_W-1:0] r_a, n_a;
    logic [MP_W-1:0]          r_p, n_p;
    logic signed [COEF_W:0]   w_hi;
    logic signed [COEF_W:0]   w_a;
    logic signed [COEF_W:0]   w_add;
    logic signed [COEF_W:0]   w_sum;
    logic                     w_last;

    always_comb begin
        w_last = r_cnt == STEP_W'(1);
        w_hi   = {r_p[MP_W-1], r_p[MP_W-1:MB_W]};
        w_a    = {r_a[COEF_W-1], r_a};
        w_add  = '0;
        if (r_p[0]) begin
            w_add = w_last ? -w_a : w_a;
        end
        w_sum  = w_hi + w_add;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_p    = r_p;
        if (i_req.start) begin
            n_cnt  = STEP_W'(MB_W);
            n_busy = 1'b1;
            n_a    = i_req.a;
            n_p    = {{COEF_W{1'b0}}, i_req.b};
        end else if (r_busy) begin
            n_p   = {w_sum, r_p[MB_W-1:1]};
            n_cnt = r_cnt - STEP_W'(1);
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_p <= n_p;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

// ----- rtl/warmup_shelf_eq_decimator.sv -----
// ----------------------------------------------------------------------------
// warmup_shelf_eq_decimator
// Warm-up gain, direct-form-1 high-shelf biquad and 2:1 averaging decimator.
//
//   port     | dir | transaction carries
//   ---------+-----+---------------------------------------------
//   i_in     | in  | sample_in (Q1.15), frames_done
//   o_out    | out | out_sample, one per two input transactions
//   i_cfg_*  | in  | register write: index, data (26 bits)
//
// An input is processed by six passes of the bit-serial multiplier and, while
// the gain ramps, one pass of the divider before them.
// Synchronous active-low reset restores the register defaults and clears the
// filter history and pair phase; no clearing pass is needed.
// A new input is taken while a result waits in the output register; the
// second item of a pair holds in its final step until that register is free.
// ----------------------------------------------------------------------------
module warmup_shelf_eq_decimator #(
    parameter int COEF_FRAC = wsed_pkg::COEF_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wsed_in_if.sink                           i_in,
    wsed_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [wsed_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wsed_pkg::CFG_W-1:0]        i_cfg_data
);
    import wsed_pkg::*;

    localparam logic [2:0] TAP_B0   = 3'd0;
    localparam logic [2:0] TAP_B1   = 3'd1;
    localparam logic [2:0] TAP_B2   = 3'd2;
    localparam logic [2:0] TAP_A1   = 3'd3;
    localparam logic [2:0] TAP_A2   = 3'd4;
    localparam logic [2:0] TAP_LAST = TAP_A2;

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] Y24_HI = (ACC_W'(1) << (YH_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y24_LO = ~Y24_HI;
    localparam logic signed [ACC_W-1:0] Y16_HI = (ACC_W'(1) << (SAMP_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y16_LO = ~Y16_HI;

    t_state r_state, n_state;

    logic signed [COEF_W-1:0] r_b0, n_b0, r_b1, n_b1, r_b2, n_b2, r_a1, n_a1, r_a2, n_a2;
    logic [CNT_W-1:0]         r_mute, n_mute, r_fade, n_fade;

    logic signed [XH_W-1:0]   r_x1, n_x1, r_x2, n_x2;
    logic signed [YH_W-1:0]   r_y1, n_y1, r_y2, n_y2;
    logic                     r_pair_phase, n_pair_phase;
    logic signed [SAMP_W-1:0] r_pair_first, n_pair_first;
    logic                     r_out_valid, n_out_valid;
    logic signed [SAMP_W-1:0] r_out_sample, n_out_sample;

    logic signed [SAMP_W-1:0] r_sample, n_sample;
    logic [FRM_W-1:0]         r_frames, n_frames;
    logic [GAIN_W-1:0]        r_gain, n_gain;
    logic signed [XH_W-1:0]   r_x, n_x;
    logic [2:0]               r_tap, n_tap;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_neg, n_neg;

    t_mul_req w_mreq;
    t_mul_rsp w_mrsp;
    t_div_req w_dreq;
    t_div_rsp w_drsp;

    logic [FRM_W-1:0]         w_d;
    logic signed [ACC_W-1:0]  w_pext;
    logic signed [YH_W-1:0]   w_y24;
    logic signed [SAMP_W-1:0] w_y16;
    logic signed [SAMP_W:0]   w_pair_sum;
    logic                     w_hist_upd;

    wsed_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    wsed_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_comb begin
        n_b0 = r_b0;
        n_b1 = r_b1;
        n_b2 = r_b2;
        n_a1 = r_a1;
        n_a2 = r_a2;
        n_mute = r_mute;
        n_fade = r_fade;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_B0:   n_b0 = i_cfg_data;
                CFG_B1:   n_b1 = i_cfg_data;
                CFG_B2:   n_b2 = i_cfg_data;
                CFG_A1:   n_a1 = i_cfg_data;
                CFG_A2:   n_a2 = i_cfg_data;
                CFG_MUTE: n_mute = i_cfg_data[CNT_W-1:0];
                CFG_FADE: n_fade = i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_x1         = r_x1;
        n_x2         = r_x2;
        n_y1         = r_y1;
        n_y2         = r_y2;
        n_pair_phase = r_pair_phase;
        n_pair_first = r_pair_first;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_sample = r_out_sample;
        n_sample     = r_sample;
        n_frames     = r_frames;
        n_gain       = r_gain;
        n_x          = r_x;
        n_tap        = r_tap;
        n_acc        = r_acc;
        n_neg        = r_neg;
        w_mreq       = '0;
        w_dreq       = '0;
        w_hist_upd   = 1'b0;
        i_in.ready   = 1'b0;

        w_d    = r_frames - {{(FRM_W - CNT_W){1'b0}}, r_mute};
        w_pext = {{(ACC_W - MP_W){w_mrsp.p[MP_W-1]}}, w_mrsp.p};

        if (r_acc > Y24_HI) begin
            w_y24 = {1'b0, {(YH_W - 1){1'b1}}};
        end else if (r_acc < Y24_LO) begin
            w_y24 = {1'b1, {(YH_W - 1){1'b0}}};
        end else begin
            w_y24 = r_acc[YH_W-1:0];
        end
        if (r_acc > Y16_HI) begin
            w_y16 = {1'b0, {(SAMP_W - 1){1'b1}}};
        end else if (r_acc < Y16_LO) begin
            w_y16 = {1'b1, {(SAMP_W - 1){1'b0}}};
        end else begin
            w_y16 = r_acc[SAMP_W-1:0];
        end
        w_pair_sum = {r_pair_first[SAMP_W-1], r_pair_first} + {w_y16[SAMP_W-1], w_y16};

        case (r_tap)
            TAP_B0: begin
                w_mreq.a = r_b0;
                w_mreq.b = {{(MB_W - XH_W){r_x[XH_W-1]}}, r_x};
            end
            TAP_B1: begin
                w_mreq.a = r_b1;
                w_mreq.b = {{(MB_W - XH_W){r_x1[XH_W-1]}}, r_x1};
            end
            TAP_B2: begin
                w_mreq.a = r_b2;
                w_mreq.b = {{(MB_W - XH_W){r_x2[XH_W-1]}}, r_x2};
            end
            TAP_A1: begin
                w_mreq.a = r_a1;
                w_mreq.b = r_y1;
            end
            TAP_A2: begin
                w_mreq.a = r_a2;
                w_mreq.b = r_y2;
            end
            default: begin
                w_mreq.a = '0;
                w_mreq.b = '0;
            end
        endcase

        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_sample = i_in.sample_in;
                    n_frames = i_in.frames_done;
                    n_state  = S_GAIN;
                end
            end
            S_GAIN: begin
                if (r_frames < {{(FRM_W - CNT_W){1'b0}}, r_mute}) begin
                    n_gain  = '0;
                    n_state = S_GGO;
                end else if (w_d < {{(FRM_W - CNT_W){1'b0}}, r_fade}) begin
                    w_dreq.start = 1'b1;
                    w_dreq.num   = w_d[CNT_W-1:0];
                    w_dreq.den   = r_fade;
                    n_state      = S_DIV;
                end else begin
                    n_gain  = GAIN_UNITY;
                    n_state = S_GGO;
                end
            end
            S_DIV: begin
                if (w_drsp.done) begin
                    n_gain  = {{(GAIN_W - QUO_W){1'b0}}, w_drsp.quo};
                    n_state = S_GGO;
                end
            end
            S_GGO: begin
                w_mreq.start = 1'b1;
                w_mreq.a     = {{(COEF_W - SAMP_W){r_sample[SAMP_W-1]}}, r_sample};
                w_mreq.b     = {{(MB_W - GAIN_W){1'b0}}, r_gain};
                n_state      = S_GMUL;
            end
            S_GMUL: begin
                if (w_mrsp.done) begin
                    n_x     = w_mrsp.p[GAIN_FRAC+XH_W-1:GAIN_FRAC];
                    n_acc   = '0;
                    n_tap   = TAP_B0;
                    n_state = S_TAPGO;
                end
            end
            S_TAPGO: begin
                w_mreq.start = 1'b1;
                n_state      = S_TAP;
            end
            S_TAP: begin
                if (w_mrsp.done) begin
                    if (r_tap == TAP_A1 || r_tap == TAP_A2) begin
                        n_acc = r_acc - w_pext;
                    end else begin
                        n_acc = r_acc + w_pext;
                    end
                    if (r_tap == TAP_LAST) begin
                        n_state = S_ABS;
                    end else begin
                        n_tap   = r_tap + 3'd1;
                        n_state = S_TAPGO;
                    end
                end
            end
            S_ABS: begin
                n_neg   = r_acc[ACC_W-1];
                n_acc   = r_acc[ACC_W-1] ? -r_acc : r_acc;
                n_state = S_RND;
            end
            S_RND: begin
                n_acc   = (r_acc + HALF) >> COEF_FRAC;
                n_state = S_SGN;
            end
            S_SGN: begin
                n_acc   = r_neg ? -r_acc : r_acc;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_pair_phase) begin
                    n_pair_first = w_y16;
                    n_pair_phase = 1'b1;
                    w_hist_upd   = 1'b1;
                    n_state      = S_IDLE;
                end else if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_pair_sum[SAMP_W:1];
                    n_pair_phase = 1'b0;
                    w_hist_upd   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_hist_upd) begin
            n_x2 = r_x1;
            n_x1 = r_x;
            n_y2 = r_y1;
            n_y1 = w_y24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_b0         <= RST_B0;
            r_b1         <= RST_B1;
            r_b2         <= RST_B2;
            r_a1         <= RST_A1;
            r_a2         <= RST_A2;
            r_mute       <= RST_MUTE;
            r_fade       <= RST_FADE;
            r_x1         <= '0;
            r_x2         <= '0;
            r_y1         <= '0;
            r_y2         <= '0;
            r_pair_phase <= 1'b0;
            r_pair_first <= '0;
            r_out_valid  <= 1'b0;
            r_tap        <= TAP_B0;
        end else begin
            r_state      <= n_state;
            r_b0         <= n_b0;
            r_b1         <= n_b1;
            r_b2         <= n_b2;
            r_a1         <= n_a1;
            r_a2         <= n_a2;
            r_mute       <= n_mute;
            r_fade       <= n_fade;
            r_x1         <= n_x1;
            r_x2         <= n_x2;
            r_y1         <= n_y1;
            r_y2         <= n_y2;
            r_pair_phase <= n_pair_phase;
            r_pair_first <= n_pair_first;
            r_out_valid  <= n_out_valid;
            r_tap        <= n_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
        r_sample     <= n_sample;
        r_frames     <= n_frames;
        r_gain       <= n_gain;
        r_x          <= n_x;
        r_acc        <= n_acc;
        r_neg        <= n_neg;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_sample;

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mrsp.done |-> (r_state == S_GMUL || r_state == S_TAP))
        else $error("multiplier result outside a product wait");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> r_state == S_DIV)
        else $error("divider result outside the gain wait");

    a_phase_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && n_state == S_IDLE) |=> r_pair_phase != $past(r_pair_phase))
        else $error("pair phase did not advance on item completion");

    a_result_on_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && !o_out.ready)) |-> (r_state == S_FIN && r_pair_phase))
        else $error("result produced outside the second item of a pair");

endmodule
